// ===== rtl/mfr_pkg.sv =====
package mfr_pkg;

    // Link-layer control characters
    localparam logic [7:0] BYTE_ACK   = 8'hE5;
    localparam logic [7:0] BYTE_SHORT = 8'h10;
    localparam logic [7:0] BYTE_LONG  = 8'h68;
    localparam logic [7:0] BYTE_STOP  = 8'h16;

    // Frame geometry
    localparam logic [8:0] SHORT_LEN     = 9'd5;
    localparam logic [8:0] LONG_OVERHEAD = 9'd6;

    // Item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY  = 1'd1;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] GAP_LIMIT_RST = 16'd50;
    localparam logic [8:0]  CAPACITY_RST  = 9'd261;

    typedef enum logic [3:0] {
        ST_IN_PROGRESS  = 4'd0,
        ST_ACK          = 4'd1,
        ST_FRAME_OK     = 4'd2,
        ST_TIMEOUT      = 4'd3,
        ST_LEN_MISMATCH = 4'd4,
        ST_BAD_START2   = 4'd5,
        ST_TOO_LONG     = 4'd6,
        ST_BAD_STOP     = 4'd7,
        ST_BAD_CHECKSUM = 4'd8
    } status_t;

    typedef struct packed {
        logic [15:0] gap_limit;
        logic [8:0]  capacity;
    } cfg_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [8:0] byte_offset;
        logic       done_res;
        status_t    status;
        logic [8:0] frame_length;
    } result_t;

endpackage

// ===== rtl/mbus_frame_receiver_top.sv =====
// M-Bus link-layer frame receiver. Feed it one item per received UART byte
// (s_action = 0) or per time tick (s_action = 1). It hunts for the start
// characters E5 (single-character ack), 10 (short frame) and 68 (long frame),
// checks the long-frame header, the capacity, the stop byte and the 8-bit
// checksum, and emits at most one result item per input item: each accepted
// frame byte with its offset, and on the last one done_res with a status.
// Errors (including an inter-byte gap of gap_limit ticks) end the frame with
// an error status and return the block to hunting. Each item waits in the
// input register, where the combinational decode updates the frame state,
// and its result is captured in the output register, so a new item is taken
// every cycle unless the decode stage stalls; m_ready low stalls the decode
// stage only once the output register holds an untaken result.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata: register 0 =
// gap_limit (reset 50), register 1 = capacity (reset 261); write it only
// while no item is in flight.
module mbus_frame_receiver_top
    import mfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [7:0]            s_rx_byte,

    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_data_valid,
    output logic [7:0]            m_data_byte,
    output logic [8:0]            m_byte_offset,
    output logic                  m_done_res,
    output logic [3:0]            m_status,
    output logic [8:0]            m_frame_length
);

    cfg_t    cfg;
    logic    in_valid_reg,  in_valid_next;
    logic    in_action_reg;
    logic [7:0] in_byte_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    proceed;
    logic    res_valid;
    result_t res;

    mfr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Decode the held item once the output register can take its result
    assign proceed = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;

    mfr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_fire   (proceed),
        .item_action (in_action_reg),
        .item_byte   (in_byte_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proceed) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proceed) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_byte_reg   <= s_rx_byte;
        end
        if (proceed) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_data_valid   = out_reg.data_valid;
    assign m_data_byte    = out_reg.data_byte;
    assign m_byte_offset  = out_reg.byte_offset;
    assign m_done_res     = out_reg.done_res;
    assign m_status       = out_reg.status;
    assign m_frame_length = out_reg.frame_length;

endmodule

// ===== rtl/mfr_cfg.sv =====
module mfr_cfg
    import mfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IDX_GAP_LIMIT: cfg_next.gap_limit = cfg_wdata;
                CFG_IDX_CAPACITY:  cfg_next.capacity  = cfg_wdata[8:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_limit <= GAP_LIMIT_RST;
            cfg_reg.capacity  <= CAPACITY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/mfr_core.sv =====
module mfr_core
    import mfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       item_fire,
    input  logic       item_action,
    input  logic [7:0] item_byte,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN1   = 3'd1,
        PH_LEN2   = 3'd2,
        PH_START2 = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    phase_t      phase_reg,           phase_next;
    logic [8:0]  position_reg,        position_next;
    logic [8:0]  expected_length_reg, expected_length_next;
    logic [7:0]  first_length_reg,    first_length_next;
    logic [7:0]  running_sum_reg,     running_sum_next;
    logic        sum_matched_reg,     sum_matched_next;
    logic [15:0] gap_count_reg,       gap_count_next;

    logic        hunt;
    logic [15:0] gap_inc;
    logic [9:0]  off_plus1;
    logic [9:0]  off_plus2;
    logic [9:0]  exp_wide;

    // Build an error result; the caller drops back to hunting
    function automatic result_t err_result(input status_t st);
        result_t r;
        r          = '0;
        r.done_res = 1'b1;
        r.status   = st;
        return r;
    endfunction

    always_comb begin
        phase_next           = phase_reg;
        position_next        = position_reg;
        expected_length_next = expected_length_reg;
        first_length_next    = first_length_reg;
        running_sum_next     = running_sum_reg;
        sum_matched_next     = sum_matched_reg;
        gap_count_next       = gap_count_reg;
        hunt                 = 1'b0;
        res_valid            = 1'b0;
        res                  = '0;

        gap_inc   = (gap_count_reg != 16'hFFFF) ? gap_count_reg + 16'd1 : gap_count_reg;
        off_plus1 = {1'b0, position_reg} + 10'd1;
        off_plus2 = {1'b0, position_reg} + 10'd2;
        exp_wide  = {1'b0, expected_length_reg};

        if (item_fire) begin
            if (item_action == ACT_TICK) begin
                if (phase_reg != PH_HUNT) begin
                    gap_count_next = gap_inc;
                    if (gap_inc >= cfg.gap_limit) begin
                        hunt      = 1'b1;
                        res_valid = 1'b1;
                        res       = err_result(ST_TIMEOUT);
                    end
                end
            end else begin
                gap_count_next = '0;
                case (phase_reg)
                    PH_HUNT: begin
                        if (item_byte inside {BYTE_ACK, BYTE_SHORT, BYTE_LONG}) begin
                            res_valid = 1'b1;
                            if (cfg.capacity < LONG_OVERHEAD) begin
                                hunt = 1'b1;
                                res  = err_result(ST_TOO_LONG);
                            end else if (item_byte == BYTE_ACK) begin
                                hunt             = 1'b1;
                                res.data_valid   = 1'b1;
                                res.data_byte    = item_byte;
                                res.done_res     = 1'b1;
                                res.status       = ST_ACK;
                                res.frame_length = 9'd1;
                            end else begin
                                position_next    = 9'd1;
                                running_sum_next = '0;
                                sum_matched_next = 1'b0;
                                if (item_byte == BYTE_SHORT) begin
                                    phase_next           = PH_BODY;
                                    expected_length_next = SHORT_LEN;
                                end else begin
                                    phase_next = PH_LEN1;
                                end
                                res.data_valid = 1'b1;
                                res.data_byte  = item_byte;
                            end
                        end
                    end
                    PH_LEN1: begin
                        first_length_next = item_byte;
                        phase_next        = PH_LEN2;
                        position_next     = 9'd2;
                        res_valid         = 1'b1;
                        res.data_valid    = 1'b1;
                        res.data_byte     = item_byte;
                        res.byte_offset   = 9'd1;
                    end
                    PH_LEN2: begin
                        expected_length_next = LONG_OVERHEAD + {1'b0, item_byte};
                        phase_next           = PH_START2;
                        position_next        = 9'd3;
                        res_valid            = 1'b1;
                        res.data_valid       = 1'b1;
                        res.data_byte        = item_byte;
                        res.byte_offset      = 9'd2;
                    end
                    PH_START2: begin
                        res_valid = 1'b1;
                        if (({1'b0, first_length_reg} + LONG_OVERHEAD) != expected_length_reg) begin
                            hunt = 1'b1;
                            res  = err_result(ST_LEN_MISMATCH);
                        end else if (item_byte != BYTE_LONG) begin
                            hunt = 1'b1;
                            res  = err_result(ST_BAD_START2);
                        end else if (expected_length_reg > cfg.capacity) begin
                            hunt = 1'b1;
                            res  = err_result(ST_TOO_LONG);
                        end else begin
                            phase_next      = PH_BODY;
                            position_next   = 9'd4;
                            res.data_valid  = 1'b1;
                            res.data_byte   = item_byte;
                            res.byte_offset = 9'd3;
                        end
                    end
                    PH_BODY: begin
                        res_valid = 1'b1;
                        if (off_plus1 >= exp_wide) begin
                            hunt = 1'b1;
                            if (item_byte != BYTE_STOP) begin
                                res = err_result(ST_BAD_STOP);
                            end else if (!sum_matched_reg) begin
                                res = err_result(ST_BAD_CHECKSUM);
                            end else begin
                                res.data_valid   = 1'b1;
                                res.data_byte    = item_byte;
                                res.byte_offset  = position_reg;
                                res.done_res     = 1'b1;
                                res.status       = ST_FRAME_OK;
                                res.frame_length = expected_length_reg;
                            end
                        end else begin
                            // The byte before the stop is the checksum: compare, don't add
                            if (off_plus2 == exp_wide) begin
                                sum_matched_next = (running_sum_reg == item_byte);
                            end else begin
                                running_sum_next = running_sum_reg + item_byte;
                            end
                            position_next   = off_plus1[8:0];
                            res.data_valid  = 1'b1;
                            res.data_byte   = item_byte;
                            res.byte_offset = position_reg;
                        end
                    end
                    default: begin
                        hunt = 1'b1;
                    end
                endcase
            end
        end

        if (hunt) begin
            phase_next           = PH_HUNT;
            position_next        = '0;
            expected_length_next = '0;
            first_length_next    = '0;
            running_sum_next     = '0;
            sum_matched_next     = 1'b0;
            gap_count_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HUNT;
            position_reg        <= '0;
            expected_length_reg <= '0;
            first_length_reg    <= '0;
            running_sum_reg     <= '0;
            sum_matched_reg     <= 1'b0;
            gap_count_reg       <= '0;
        end else begin
            phase_reg           <= phase_next;
            position_reg        <= position_next;
            expected_length_reg <= expected_length_next;
            first_length_reg    <= first_length_next;
            running_sum_reg     <= running_sum_next;
            sum_matched_reg     <= sum_matched_next;
            gap_count_reg       <= gap_count_next;
        end
    end

endmodule
